>>> rtl/cpu65_pkg.sv
`default_nettype none
package cpu65_pkg;

   localparam logic [15:0] RESET_PC_DEFAULT = 16'hF000;
   localparam logic [15:0] BRK_VECTOR       = 16'hFFFE;
   localparam logic [7:0]  STACK_PAGE       = 8'h01;

   // sequencer phases
   localparam logic [3:0] PH_START = 4'd0;
   localparam logic [3:0] PH_OPC   = 4'd1;
   localparam logic [3:0] PH_OP1   = 4'd2;
   localparam logic [3:0] PH_OP2   = 4'd3;
   localparam logic [3:0] PH_PTR1  = 4'd4;
   localparam logic [3:0] PH_PTR2  = 4'd5;
   localparam logic [3:0] PH_DATA  = 4'd6;
   localparam logic [3:0] PH_WR    = 4'd7;
   localparam logic [3:0] PH_S1    = 4'd8;
   localparam logic [3:0] PH_S2    = 4'd9;
   localparam logic [3:0] PH_S3    = 4'd10;
   localparam logic [3:0] PH_S4    = 4'd11;
   localparam logic [3:0] PH_S5    = 4'd12;

   // addressing modes
   localparam logic [4:0] M_IMP  = 5'd0;
   localparam logic [4:0] M_ACC  = 5'd1;
   localparam logic [4:0] M_IMM  = 5'd2;
   localparam logic [4:0] M_ZP   = 5'd3;
   localparam logic [4:0] M_ZPX  = 5'd4;
   localparam logic [4:0] M_ZPY  = 5'd5;
   localparam logic [4:0] M_ABS  = 5'd6;
   localparam logic [4:0] M_ABSX = 5'd7;
   localparam logic [4:0] M_ABSY = 5'd8;
   localparam logic [4:0] M_INDX = 5'd9;
   localparam logic [4:0] M_INDY = 5'd10;
   localparam logic [4:0] M_IND  = 5'd11;
   localparam logic [4:0] M_REL  = 5'd12;
   localparam logic [4:0] M_BRK  = 5'd13;
   localparam logic [4:0] M_JSR  = 5'd14;
   localparam logic [4:0] M_JMP  = 5'd15;
   localparam logic [4:0] M_RTI  = 5'd16;
   localparam logic [4:0] M_RTS  = 5'd17;
   localparam logic [4:0] M_PUSH = 5'd18;
   localparam logic [4:0] M_PULL = 5'd19;

   // status bit positions
   localparam int F_C = 0;
   localparam int F_Z = 1;
   localparam int F_I = 2;
   localparam int F_D = 3;
   localparam int F_V = 4;
   localparam int F_N = 5;

   // opcodes with special handling
   localparam logic [7:0] OP_PHP = 8'h08;
   localparam logic [7:0] OP_PLA = 8'h68;

   typedef struct packed {
      logic [4:0] mode;
      logic       store;
      logic       rmw;
   } decode_type;

endpackage
`default_nettype wire

>>> rtl/cpu65_decode.sv
`default_nettype none
module cpu65_decode
   import cpu65_pkg::*;
(
   input  wire logic [7:0] opcode,
   output decode_type      dec
);

   logic [2:0] aaa;
   logic [2:0] bbb;
   logic [1:0] cc;
   logic [4:0] mode;

   assign aaa = opcode[7:5];
   assign bbb = opcode[4:2];
   assign cc  = opcode[1:0];

   always_comb begin
      mode = M_IMP;
      unique case (opcode)
         8'h00: mode = M_BRK;
         8'h20: mode = M_JSR;
         8'h40: mode = M_RTI;
         8'h60: mode = M_RTS;
         8'h08, 8'h48: mode = M_PUSH;
         8'h28, 8'h68: mode = M_PULL;
         8'h4C: mode = M_JMP;
         8'h6C: mode = M_IND;
         8'h89: mode = M_IMP;
         default: begin
            if (cc == 2'd1) begin
               unique case (bbb)
                  3'd0: mode = M_INDX;
                  3'd1: mode = M_ZP;
                  3'd2: mode = M_IMM;
                  3'd3: mode = M_ABS;
                  3'd4: mode = M_INDY;
                  3'd5: mode = M_ZPX;
                  3'd6: mode = M_ABSY;
                  default: mode = M_ABSX;
               endcase
            end else if (cc == 2'd0) begin
               if (bbb == 3'd4) mode = M_REL;
               else if (bbb == 3'd1 && aaa != 3'd0 && aaa != 3'd2 && aaa != 3'd3) mode = M_ZP;
               else if (bbb == 3'd3 && aaa != 3'd0) mode = M_ABS;
               else if (bbb == 3'd0 && aaa >= 3'd5) mode = M_IMM;
               else if (bbb == 3'd5 && (aaa == 3'd4 || aaa == 3'd5)) mode = M_ZPX;
               else if (bbb == 3'd7 && aaa == 3'd5) mode = M_ABSX;
               else mode = M_IMP;
            end else if (cc == 2'd2) begin
               if (bbb == 3'd1) mode = M_ZP;
               else if (bbb == 3'd3) mode = M_ABS;
               else if (bbb == 3'd2 && aaa < 3'd4) mode = M_ACC;
               else if (bbb == 3'd5) mode = (aaa == 3'd4 || aaa == 3'd5) ? M_ZPY : M_ZPX;
               else if (bbb == 3'd7 && aaa != 3'd4) mode = (aaa == 3'd5) ? M_ABSY : M_ABSX;
               else if (bbb == 3'd0 && aaa == 3'd5) mode = M_IMM;
               else mode = M_IMP;
            end
         end
      endcase
   end

   assign dec.mode  = mode;
   assign dec.store = (aaa == 3'd4);
   assign dec.rmw   = (cc == 2'd2) && (aaa != 3'd4) && (aaa != 3'd5);

endmodule
`default_nettype wire

>>> rtl/cpu65_exec.sv
`default_nettype none
module cpu65_exec
   import cpu65_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic        action,
   input  wire logic [7:0]  read_data,
   input  wire logic [15:0] reset_pc,
   output logic [15:0]      bus_address,
   output logic             bus_write,
   output logic [7:0]       write_data,
   output logic             opcode_fetch
);

   logic [7:0]  a_ff, a_in, x_ff, x_in, y_ff, y_in, sp_ff, sp_in;
   logic [7:0]  op_ff, op_in, dl_ff, dl_in;
   logic [15:0] pc_ff, pc_in, al_ff, al_in;
   logic [5:0]  p_ff, p_in;
   logic [3:0]  ph_ff, ph_in;
   logic [15:0] qa_ff, qa_in;
   logic        qw_ff, qw_in, qf_ff, qf_in;
   logic [7:0]  qd_ff, qd_in;

   decode_type  dec;
   logic [7:0]  dec_op;
   logic [15:0] t_word;
   logic [15:0] pc_inc;
   logic [7:0]  pack_p;
   logic [8:0]  rmw_res;
   logic [7:0]  store_val;

   // decode the fresh opcode in the fetch phase, the latched one afterwards
   assign dec_op = (ph_ff == PH_OPC) ? read_data : op_ff;
   cpu65_decode u_decode (.opcode(dec_op), .dec(dec));

   assign t_word = {read_data, dl_ff};
   assign pc_inc = pc_ff + 16'd1;
   assign pack_p = {p_ff[F_N], p_ff[F_V], 2'b11, p_ff[3:0]};

   always_comb begin
      unique case (op_ff[1:0])
         2'd1: store_val = a_ff;
         2'd2: store_val = x_ff;
         default: store_val = y_ff;
      endcase
   end

   // shift / rotate / inc / dec: carry out and result
   function automatic logic [8:0] rmw_calc(input logic [7:0] op, input logic [7:0] v,
                                           input logic cin);
      logic [8:0] r;
      begin
         case (op[7:5])
            3'd0: r = {v[7], v[6:0], 1'b0};
            3'd1: r = {v[7], v[6:0], cin};
            3'd2: r = {v[0], 1'b0, v[7:1]};
            3'd3: r = {v[0], cin, v[7:1]};
            3'd6: r = {cin, v - 8'd1};
            3'd7: r = {cin, v + 8'd1};
            default: r = {cin, v};
         endcase
         return r;
      end
   endfunction

   assign rmw_res = rmw_calc(op_ff, read_data, p_ff[F_C]);

   always_comb begin
      logic        fin;
      logic        go_op;
      logic [15:0] go_addr;
      logic [8:0]  sum;
      logic [7:0]  addend;
      logic [8:0]  r9;
      logic [7:0]  cmp_reg;
      logic        taken;
      logic        sel_bit;

      a_in = a_ff; x_in = x_ff; y_in = y_ff; sp_in = sp_ff;
      op_in = op_ff; dl_in = dl_ff; pc_in = pc_ff; al_in = al_ff;
      p_in = p_ff; ph_in = ph_ff;
      qa_in = qa_ff; qw_in = qw_ff; qd_in = qd_ff; qf_in = qf_ff;
      fin = 1'b0; go_op = 1'b0; go_addr = 16'h0000;
      sum = 9'h000; addend = 8'h00; r9 = 9'h000; cmp_reg = 8'h00;
      taken = 1'b0; sel_bit = 1'b0;

      if (action) begin
         if (ph_ff == PH_START) begin
            qa_in = reset_pc; qw_in = 1'b0; qd_in = 8'h00; qf_in = 1'b1;
         end
      end else begin
         unique case (ph_ff)
            PH_START: begin
               pc_in = reset_pc;
               fin = 1'b1;
            end
            PH_OPC: begin
               op_in = read_data;
               pc_in = pc_inc;
               unique case (dec.mode)
                  M_IMP, M_ACC: begin
                     fin = 1'b1;
                     case (read_data)
                        8'h0A, 8'h2A, 8'h4A, 8'h6A: begin
                           r9 = rmw_calc(read_data, a_ff, p_ff[F_C]);
                           a_in = r9[7:0];
                           p_in[F_C] = r9[8];
                           p_in[F_Z] = (r9[7:0] == 8'h00); p_in[F_N] = r9[7];
                        end
                        8'h88: begin
                           y_in = y_ff - 8'd1;
                           p_in[F_Z] = (y_in == 8'h00); p_in[F_N] = y_in[7];
                        end
                        8'hC8: begin
                           y_in = y_ff + 8'd1;
                           p_in[F_Z] = (y_in == 8'h00); p_in[F_N] = y_in[7];
                        end
                        8'hCA: begin
                           x_in = x_ff - 8'd1;
                           p_in[F_Z] = (x_in == 8'h00); p_in[F_N] = x_in[7];
                        end
                        8'hE8: begin
                           x_in = x_ff + 8'd1;
                           p_in[F_Z] = (x_in == 8'h00); p_in[F_N] = x_in[7];
                        end
                        8'hA8: begin
                           y_in = a_ff;
                           p_in[F_Z] = (a_ff == 8'h00); p_in[F_N] = a_ff[7];
                        end
                        8'hAA: begin
                           x_in = a_ff;
                           p_in[F_Z] = (a_ff == 8'h00); p_in[F_N] = a_ff[7];
                        end
                        8'h98: begin
                           a_in = y_ff;
                           p_in[F_Z] = (y_ff == 8'h00); p_in[F_N] = y_ff[7];
                        end
                        8'h8A: begin
                           a_in = x_ff;
                           p_in[F_Z] = (x_ff == 8'h00); p_in[F_N] = x_ff[7];
                        end
                        8'hBA: begin
                           x_in = sp_ff;
                           p_in[F_Z] = (sp_ff == 8'h00); p_in[F_N] = sp_ff[7];
                        end
                        8'h9A: sp_in = x_ff;
                        8'h18: p_in[F_C] = 1'b0;
                        8'h38: p_in[F_C] = 1'b1;
                        8'h58: p_in[F_I] = 1'b0;
                        8'h78: p_in[F_I] = 1'b1;
                        8'hB8: p_in[F_V] = 1'b0;
                        8'hD8: p_in[F_D] = 1'b0;
                        8'hF8: p_in[F_D] = 1'b1;
                        default: ;
                     endcase
                  end
                  M_IMM: begin
                     pc_in = pc_inc + 16'd1;
                     go_op = 1'b1; go_addr = pc_inc;
                  end
                  M_BRK: begin
                     pc_in = pc_inc + 16'd1;
                     qa_in = {STACK_PAGE, sp_ff}; qw_in = 1'b1; qf_in = 1'b0;
                     qd_in = pc_in[15:8];
                     sp_in = sp_ff - 8'd1; ph_in = PH_S1;
                  end
                  M_RTS, M_RTI, M_PULL: begin
                     sp_in = sp_ff + 8'd1;
                     qa_in = {STACK_PAGE, sp_in}; qw_in = 1'b0; qd_in = 8'h00; qf_in = 1'b0;
                     ph_in = PH_S1;
                  end
                  M_PUSH: begin
                     qa_in = {STACK_PAGE, sp_ff}; qw_in = 1'b1; qf_in = 1'b0;
                     qd_in = (read_data == OP_PHP) ? pack_p : a_ff;
                     sp_in = sp_ff - 8'd1; ph_in = PH_WR;
                  end
                  default: begin
                     qa_in = pc_inc; qw_in = 1'b0; qd_in = 8'h00; qf_in = 1'b0;
                     pc_in = pc_inc + 16'd1; ph_in = PH_OP1;
                  end
               endcase
            end
            PH_OP1: begin
               unique case (dec.mode)
                  M_REL: begin
                     unique case (op_ff[7:6])
                        2'd0: sel_bit = p_ff[F_N];
                        2'd1: sel_bit = p_ff[F_V];
                        2'd2: sel_bit = p_ff[F_C];
                        default: sel_bit = p_ff[F_Z];
                     endcase
                     taken = (sel_bit == op_ff[5]);
                     if (taken) pc_in = pc_ff + {{8{read_data[7]}}, read_data};
                     fin = 1'b1;
                  end
                  M_ZP: begin go_op = 1'b1; go_addr = {8'h00, read_data}; end
                  M_ZPX: begin go_op = 1'b1; go_addr = {8'h00, read_data + x_ff}; end
                  M_ZPY: begin go_op = 1'b1; go_addr = {8'h00, read_data + y_ff}; end
                  M_INDX, M_INDY: begin
                     al_in = {8'h00, (dec.mode == M_INDX) ? read_data + x_ff : read_data};
                     qa_in = al_in; qw_in = 1'b0; qd_in = 8'h00; qf_in = 1'b0;
                     ph_in = PH_PTR1;
                  end
                  M_JSR: begin
                     dl_in = read_data;
                     qa_in = {STACK_PAGE, sp_ff}; qw_in = 1'b1; qf_in = 1'b0;
                     qd_in = pc_ff[15:8];
                     sp_in = sp_ff - 8'd1; ph_in = PH_S1;
                  end
                  default: begin
                     dl_in = read_data;
                     qa_in = pc_ff; qw_in = 1'b0; qd_in = 8'h00; qf_in = 1'b0;
                     pc_in = pc_inc; ph_in = PH_OP2;
                  end
               endcase
            end
            PH_OP2: begin
               unique case (dec.mode)
                  M_ABS: begin go_op = 1'b1; go_addr = t_word; end
                  M_ABSX: begin go_op = 1'b1; go_addr = t_word + {8'h00, x_ff}; end
                  M_ABSY: begin go_op = 1'b1; go_addr = t_word + {8'h00, y_ff}; end
                  M_JMP: begin pc_in = t_word; fin = 1'b1; end
                  M_IND: begin
                     al_in = t_word;
                     qa_in = t_word; qw_in = 1'b0; qd_in = 8'h00; qf_in = 1'b0;
                     ph_in = PH_PTR1;
                  end
                  default: fin = 1'b1;
               endcase
            end
            PH_PTR1: begin
               dl_in = read_data;
               // pointer high byte stays in the same page
               qa_in = {(dec.mode == M_IND) ? al_ff[15:8] : 8'h00, al_ff[7:0] + 8'd1};
               qw_in = 1'b0; qd_in = 8'h00; qf_in = 1'b0;
               ph_in = PH_PTR2;
            end
            PH_PTR2: begin
               if (dec.mode == M_IND) begin
                  pc_in = t_word; fin = 1'b1;
               end else if (dec.mode == M_INDY) begin
                  go_op = 1'b1; go_addr = t_word + {8'h00, y_ff};
               end else begin
                  go_op = 1'b1; go_addr = t_word;
               end
            end
            PH_DATA: begin
               if (dec.rmw) begin
                  qa_in = al_ff; qw_in = 1'b1; qd_in = rmw_res[7:0]; qf_in = 1'b0;
                  p_in[F_C] = rmw_res[8];
                  p_in[F_Z] = (rmw_res[7:0] == 8'h00); p_in[F_N] = rmw_res[7];
                  ph_in = PH_WR;
               end else begin
                  fin = 1'b1;
                  if (op_ff[1:0] == 2'd1) begin
                     case (op_ff[7:5])
                        3'd0: a_in = a_ff | read_data;
                        3'd1: a_in = a_ff & read_data;
                        3'd2: a_in = a_ff ^ read_data;
                        3'd5: a_in = read_data;
                        default: ;
                     endcase
                     if (op_ff[7:5] == 3'd3 || op_ff[7:5] == 3'd7) begin
                        addend = (op_ff[7:5] == 3'd7) ? ~read_data : read_data;
                        sum = {1'b0, a_ff} + {1'b0, addend} + {8'h00, p_ff[F_C]};
                        a_in = sum[7:0];
                        p_in[F_V] = ~(a_ff[7] ^ addend[7]) & (a_ff[7] ^ sum[7]);
                        p_in[F_C] = sum[8];
                     end
                     if (op_ff[7:5] == 3'd6) begin
                        r9 = {1'b0, a_ff} - {1'b0, read_data};
                        p_in[F_C] = ~r9[8];
                        p_in[F_Z] = (r9[7:0] == 8'h00); p_in[F_N] = r9[7];
                     end else if (op_ff[7:5] != 3'd4) begin
                        p_in[F_Z] = (a_in == 8'h00); p_in[F_N] = a_in[7];
                     end
                  end else if (op_ff[1:0] == 2'd2) begin
                     if (op_ff[7:5] == 3'd5) begin
                        x_in = read_data;
                        p_in[F_Z] = (read_data == 8'h00); p_in[F_N] = read_data[7];
                     end
                  end else begin
                     case (op_ff[7:5])
                        3'd1: begin
                           p_in[F_N] = read_data[7];
                           p_in[F_V] = read_data[6];
                           p_in[F_Z] = ((read_data & a_ff) == 8'h00);
                        end
                        3'd5: begin
                           y_in = read_data;
                           p_in[F_Z] = (read_data == 8'h00); p_in[F_N] = read_data[7];
                        end
                        3'd6, 3'd7: begin
                           cmp_reg = (op_ff[7:5] == 3'd6) ? y_ff : x_ff;
                           r9 = {1'b0, cmp_reg} - {1'b0, read_data};
                           p_in[F_C] = ~r9[8];
                           p_in[F_Z] = (r9[7:0] == 8'h00); p_in[F_N] = r9[7];
                        end
                        default: ;
                     endcase
                  end
               end
            end
            PH_S1: begin
               if (dec.mode == M_BRK || dec.mode == M_JSR) begin
                  qa_in = {STACK_PAGE, sp_ff}; qw_in = 1'b1; qf_in = 1'b0;
                  qd_in = pc_ff[7:0];
                  sp_in = sp_ff - 8'd1; ph_in = PH_S2;
               end else if (dec.mode == M_RTS || dec.mode == M_RTI) begin
                  if (dec.mode == M_RTS) dl_in = read_data;
                  else p_in = {read_data[7:6], read_data[3:0]};
                  sp_in = sp_ff + 8'd1;
                  qa_in = {STACK_PAGE, sp_in}; qw_in = 1'b0; qd_in = 8'h00; qf_in = 1'b0;
                  ph_in = PH_S2;
               end else if (dec.mode == M_PULL) begin
                  if (op_ff == OP_PLA) begin
                     a_in = read_data;
                     p_in[F_Z] = (read_data == 8'h00); p_in[F_N] = read_data[7];
                  end else begin
                     p_in = {read_data[7:6], read_data[3:0]};
                  end
                  fin = 1'b1;
               end else begin
                  fin = 1'b1;
               end
            end
            PH_S2: begin
               if (dec.mode == M_BRK) begin
                  qa_in = {STACK_PAGE, sp_ff}; qw_in = 1'b1; qf_in = 1'b0;
                  qd_in = pack_p;
                  sp_in = sp_ff - 8'd1; ph_in = PH_S3;
                  p_in[F_I] = 1'b1;
               end else if (dec.mode == M_JSR) begin
                  qa_in = pc_ff; qw_in = 1'b0; qd_in = 8'h00; qf_in = 1'b0;
                  ph_in = PH_S3;
               end else if (dec.mode == M_RTS) begin
                  pc_in = t_word + 16'd1; fin = 1'b1;
               end else if (dec.mode == M_RTI) begin
                  dl_in = read_data;
                  sp_in = sp_ff + 8'd1;
                  qa_in = {STACK_PAGE, sp_in}; qw_in = 1'b0; qd_in = 8'h00; qf_in = 1'b0;
                  ph_in = PH_S3;
               end else begin
                  fin = 1'b1;
               end
            end
            PH_S3: begin
               if (dec.mode == M_BRK) begin
                  qa_in = BRK_VECTOR; qw_in = 1'b0; qd_in = 8'h00; qf_in = 1'b0;
                  ph_in = PH_S4;
               end else if (dec.mode == M_JSR || dec.mode == M_RTI) begin
                  pc_in = t_word; fin = 1'b1;
               end else begin
                  fin = 1'b1;
               end
            end
            PH_S4: begin
               if (dec.mode == M_BRK) begin
                  dl_in = read_data;
                  qa_in = BRK_VECTOR | 16'h0001; qw_in = 1'b0; qd_in = 8'h00; qf_in = 1'b0;
                  ph_in = PH_S5;
               end else begin
                  fin = 1'b1;
               end
            end
            PH_S5: begin
               if (dec.mode == M_BRK) pc_in = t_word;
               fin = 1'b1;
            end
            default: fin = 1'b1;
         endcase

         if (go_op) begin
            al_in = go_addr;
            qa_in = go_addr; qf_in = 1'b0;
            if (dec.store) begin
               qw_in = 1'b1; qd_in = store_val; ph_in = PH_WR;
            end else begin
               qw_in = 1'b0; qd_in = 8'h00; ph_in = PH_DATA;
            end
         end
         if (fin) begin
            qa_in = pc_in; qw_in = 1'b0; qd_in = 8'h00; qf_in = 1'b1;
            ph_in = PH_OPC;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0; x_ff <= '0; y_ff <= '0; sp_ff <= '0; p_ff <= '0;
         op_ff <= '0; dl_ff <= '0; al_ff <= '0;
         pc_ff <= RESET_PC_DEFAULT; ph_ff <= PH_START;
         qa_ff <= RESET_PC_DEFAULT; qw_ff <= 1'b0; qd_ff <= '0; qf_ff <= 1'b1;
      end else if (step) begin
         a_ff <= a_in; x_ff <= x_in; y_ff <= y_in; sp_ff <= sp_in; p_ff <= p_in;
         op_ff <= op_in; dl_ff <= dl_in; al_ff <= al_in;
         pc_ff <= pc_in; ph_ff <= ph_in;
         qa_ff <= qa_in; qw_ff <= qw_in; qd_ff <= qd_in; qf_ff <= qf_in;
      end
   end

   assign bus_address  = qa_ff;
   assign bus_write    = qw_ff;
   assign write_data   = qd_ff;
   assign opcode_fetch = qf_ff;

endmodule
`default_nettype wire

>>> rtl/cpu_6502_core.sv
// result: a request word gives its bus word in the cycle after acceptance
// throughput: one word per cycle unless the result channel stalls; the whole
//   sequencer step sits between the request handshake and the result registers
// reset: synchronous, active high; the first step issues the fetch at csr value
//   (default 0xf000), A, X, Y, SP and all flags clear, result channel empties
`default_nettype none
module cpu_6502_core
   import cpu65_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic [7:0]  req_read_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_bus_address,
   output logic             rsp_bus_write,
   output logic [7:0]       rsp_write_data,
   output logic             rsp_opcode_fetch,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data
);

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] reset_pc_ff;
   logic        accept;

   // a word may enter whenever the result register is free or being emptied
   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign accept       = req_valid & ~req_stall;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         reset_pc_ff  <= RESET_PC_DEFAULT;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) reset_pc_ff <= csr_write_data;
      end
   end

   // the bus request registers inside the sequencer double as result payload
   cpu65_exec u_exec (
      .clock       (clock),
      .reset       (reset),
      .step        (accept),
      .action      (req_action),
      .read_data   (req_read_data),
      .reset_pc    (reset_pc_ff),
      .bus_address (rsp_bus_address),
      .bus_write   (rsp_bus_write),
      .write_data  (rsp_write_data),
      .opcode_fetch(rsp_opcode_fetch)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

>>> rtl/cpu65_checker.sv
`default_nettype none
module cpu65_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_bus_address,
   input wire logic        rsp_bus_write,
   input wire logic [7:0]  rsp_write_data,
   input wire logic        rsp_opcode_fetch
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bus_address))
      else $error("stalled result changed");

   a_follow: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted word gave no result");

   a_rdzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bus_write |-> rsp_write_data == 8'h00)
      else $error("read carries write data");

   a_fetch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_opcode_fetch |-> !rsp_bus_write)
      else $error("opcode fetch marked as write");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with free result register");

endmodule

bind cpu_6502_core cpu65_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_bus_address (rsp_bus_address),
   .rsp_bus_write   (rsp_bus_write),
   .rsp_write_data  (rsp_write_data),
   .rsp_opcode_fetch(rsp_opcode_fetch)
);
`default_nettype wire
